// ----- rtl/premultiplied_alpha_converter_defines.svh -----
// ----------------------------------------------------------------------------
// premultiplied alpha converter assertion macros
// shared concurrent assertion wrappers for the converter rtl
// ----------------------------------------------------------------------------
`ifndef PREMULTIPLIED_ALPHA_CONVERTER_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_CONVERTER_DEFINES_SVH

// clocked check, masked while reset is asserted
`define PAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds across reset
`define PAM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/pam_pkg.sv -----
// ----------------------------------------------------------------------------
// pam_pkg
// shared constants and types of the premultiplied alpha converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pam_pkg;

  localparam int unsigned ChanW = 8;
  // products and colour times 255 fit in 16 bits
  localparam int unsigned NumW  = 2 * ChanW;
  // reciprocal scale, exact floor for 16 bit dividends and 8 bit divisors
  localparam int unsigned RcpK  = 24;
  localparam int unsigned RcpW  = RcpK + 1;
  localparam int unsigned ProdW = NumW + RcpW;
  localparam int unsigned TblN  = 2 ** ChanW;

  // ceil(2^24 / 255) for the premultiply divide
  localparam logic [RcpW-1:0] PremulRcp = RcpW'((2 ** RcpK + 254) / 255);
  localparam logic [ChanW-1:0] ChanMax  = {ChanW{1'b1}};

  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] AddrAlphaEnabled = AddrW'(0);

  typedef enum logic {
    MODE_PREMUL   = 1'b0,
    MODE_UNPREMUL = 1'b1
  } pam_mode_e;

  // per item control that follows the data down the pipe
  typedef struct packed {
    logic bypass;   // alpha disabled, reorder only
    logic zero;     // unpremultiply with zero alpha
    logic unpre;    // unpremultiply direction
  } pam_ctl_t;

  // stage load enables from the handshake logic
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pam_adv_t;

endpackage

// ----- rtl/pam_chan.sv -----
// ----------------------------------------------------------------------------
// pam_chan
// one colour channel of the converter: multiply, reciprocal multiply, select
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pam_chan (
  input  logic                           clk_i,
  input  pam_pkg::pam_adv_t              adv_i,
  input  logic [pam_pkg::ChanW-1:0]      chan_s1_i,
  input  logic [pam_pkg::ChanW-1:0]      alpha_s1_i,
  input  logic [pam_pkg::ChanW-1:0]      mult_s1_i,
  input  pam_pkg::pam_ctl_t              ctl_s1_i,
  input  logic [pam_pkg::RcpW-1:0]       rcp_s2_i,
  output logic [pam_pkg::ChanW-1:0]      res_o
);
  import pam_pkg::*;

  logic [NumW-1:0]  num_d, num_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [ChanW-1:0] chan2_q, chan3_q;
  logic             sat_d, sat2_q, sat3_q;
  pam_ctl_t         ctl2_q, ctl3_q;
  logic [ChanW-1:0] res_d, res_q;

  // colour at or above alpha saturates when unpremultiplying
  assign sat_d  = ctl_s1_i.unpre && (chan_s1_i >= alpha_s1_i);
  assign num_d  = NumW'(chan_s1_i) * NumW'(mult_s1_i);
  assign prod_d = ProdW'(num_q) * ProdW'(rcp_s2_i);

  always_comb begin
    if (ctl3_q.bypass) begin
      res_d = chan3_q;
    end else if (ctl3_q.zero) begin
      res_d = '0;
    end else if (sat3_q) begin
      res_d = ChanMax;
    end else begin
      res_d = prod_q[RcpK +: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      num_q   <= num_d;
      chan2_q <= chan_s1_i;
      sat2_q  <= sat_d;
      ctl2_q  <= ctl_s1_i;
    end
    if (adv_i.s3) begin
      prod_q  <= prod_d;
      chan3_q <= chan2_q;
      sat3_q  <= sat2_q;
      ctl3_q  <= ctl2_q;
    end
    if (adv_i.s4) begin
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/premultiplied_alpha_converter.sv -----
// ----------------------------------------------------------------------------
// premultiplied_alpha_converter
// rgba pixel stream converter between straight and premultiplied alpha
// ----------------------------------------------------------------------------
// The converter takes one pixel word per clock while the pipe has room and
// returns one word per pixel through input capture, channel multiply,
// reciprocal multiply, then saturate and select into the output register.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage behind it moves, so bubbles close up and a stalled output still lets
// the input side fill the pipe. Premultiply gives floor(c*a/255),
// unpremultiply floor(c*255/a) saturated at 255 and 0 for zero alpha, both
// as an exact multiply by a 25 bit reciprocal, taken from a constant table
// when unpremultiplying. Colour bytes leave in reverse order. With alpha
// disabled colours are only reordered and alpha leaves as 255. The alpha
// enable register lives at byte address 0 and resets to 1; write it only
// while no pixel is in flight.
`timescale 1ns / 1ps

`include "premultiplied_alpha_converter_defines.svh"

module premultiplied_alpha_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input pixel words
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // chan_first, chan_second,
                                                     // chan_third, alpha_in
  input  logic                        s_axis_tuser,  // mode
  // output pixel words
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // out_first, out_second,
                                                     // out_third, alpha_out
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pam_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pam_pkg::*;

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  logic alpha_en_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == AddrAlphaEnabled)) begin
      alpha_en_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == AddrAlphaEnabled) ? {31'd0, alpha_en_q} : '0;

  // --------------------------------------------------------------------------
  // handshake: per stage valid, each stage moves when empty or drained
  // --------------------------------------------------------------------------
  logic     v1_q, v2_q, v3_q, v4_q;
  logic     adv1;
  pam_adv_t adv;
  logic     in_fire;

  assign adv.s4        = !v4_q || m_axis_tready;
  assign adv.s3        = !v3_q || adv.s4;
  assign adv.s2        = !v2_q || adv.s3;
  assign adv1          = !v1_q || adv.s2;
  assign s_axis_tready = adv1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1)   v1_q <= s_axis_tvalid;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
      if (adv.s4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture the word and decode control
  // --------------------------------------------------------------------------
  logic [ChanW-1:0] c0_q, c1_q, c2_q, a1_q;
  pam_ctl_t         ctl_d, ctl1_q;
  pam_mode_e        mode_in;

  assign mode_in      = pam_mode_e'(s_axis_tuser);
  assign ctl_d.bypass = !alpha_en_q;
  assign ctl_d.unpre  = (mode_in == MODE_UNPREMUL);
  assign ctl_d.zero   = (mode_in == MODE_UNPREMUL) && (s_axis_tdata[31:24] == '0);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      c0_q   <= s_axis_tdata[7:0];
      c1_q   <= s_axis_tdata[15:8];
      c2_q   <= s_axis_tdata[23:16];
      a1_q   <= s_axis_tdata[31:24];
      ctl1_q <= ctl_d;
    end
  end

  // reciprocal table, entry a holds ceil(2^24 / a), zero alpha is caught apart
  logic [RcpW-1:0] rcp_tbl [TblN];

  assign rcp_tbl[0] = '0;
  for (genvar g = 1; g < TblN; g++) begin : g_rcp
    localparam int unsigned RcpVal = (2 ** RcpK + g - 1) / g;
    assign rcp_tbl[g] = RcpW'(RcpVal);
  end

  // unpremultiply: c*255 times 1/a, premultiply: c*a times 1/255
  logic [ChanW-1:0] mult_s1;
  logic [RcpW-1:0]  rcp_d, rcp2_q;

  assign mult_s1 = ctl1_q.unpre ? ChanMax : a1_q;
  assign rcp_d   = ctl1_q.unpre ? rcp_tbl[a1_q] : PremulRcp;

  // --------------------------------------------------------------------------
  // stages 2 to 4: alpha and reciprocal follow the channel lanes
  // --------------------------------------------------------------------------
  logic [ChanW-1:0] a2_q, a3_q, a4_q;
  logic             byp2_q, byp3_q, byp4_q;

  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      rcp2_q <= rcp_d;
      a2_q   <= a1_q;
      byp2_q <= ctl1_q.bypass;
    end
    if (adv.s3) begin
      a3_q   <= a2_q;
      byp3_q <= byp2_q;
    end
    if (adv.s4) begin
      a4_q   <= byp3_q ? ChanMax : a3_q;
      byp4_q <= byp3_q;
    end
  end

  logic [ChanW-1:0] r0, r1, r2;

  pam_chan u_chan0 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .chan_s1_i  (c0_q),
    .alpha_s1_i (a1_q),
    .mult_s1_i  (mult_s1),
    .ctl_s1_i   (ctl1_q),
    .rcp_s2_i   (rcp2_q),
    .res_o      (r0)
  );

  pam_chan u_chan1 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .chan_s1_i  (c1_q),
    .alpha_s1_i (a1_q),
    .mult_s1_i  (mult_s1),
    .ctl_s1_i   (ctl1_q),
    .rcp_s2_i   (rcp2_q),
    .res_o      (r1)
  );

  pam_chan u_chan2 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .chan_s1_i  (c2_q),
    .alpha_s1_i (a1_q),
    .mult_s1_i  (mult_s1),
    .ctl_s1_i   (ctl1_q),
    .rcp_s2_i   (rcp2_q),
    .res_o      (r2)
  );

  // colour bytes leave in reverse order
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {a4_q, r0, r1, r2};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the input side only stalls behind a full pipe and a waiting word
  `PAM_ASSERT(a_stall_only_when_full, !s_axis_tready |-> (v1_q && v2_q && v3_q && m_axis_tvalid && !m_axis_tready), "input stalled without a full pipe")
  // an accepted word reaches the output if the output side stays ready meanwhile
  `PAM_ASSERT(a_latency, ($past(rst_ni, 4) && $past(in_fire, 4) && $past(m_axis_tready, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)) |-> m_axis_tvalid, "word lost in the pipe")
  // a bypassed word always carries opaque alpha
  `PAM_ASSERT(a_bypass_alpha, (v4_q && byp4_q) |-> (m_axis_tdata[31:24] == ChanMax), "bypass word without opaque alpha")
  // reset empties the output register
  `PAM_ASSERT_RST(a_reset_clears, !$past(rst_ni) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the premultiplied alpha converter: a directed table
// of corner pixels, then random pixel words under both alpha settings, each
// result compared field by field with a typed-in value or an in-bench conversion model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pam_pkg::*;

  // byte address of register index 1, which does not exist
  localparam logic [AddrW-1:0] AddrUnused = AddrW'(4);
  // cycles after the last result before the pipe counts as empty
  localparam int unsigned PipeSlack = 8;
  // cycles with no handshake at all before the run is declared hung
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned PhaseItems = 273;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned NumRows = 18;

  // result word, out_first in the low byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] third;
    logic [7:0] second;
    logic [7:0] first;
  } pixel_out_t;

  // one directed pixel; known marks rows whose result is typed in
  typedef struct packed {
    logic       en;
    pam_mode_e  mode;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] a;
    logic       known;
    logic [31:0] res;
  } pixel_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;   // chan_first, chan_second, chan_third, alpha_in
  logic              s_axis_tuser;   // mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // out_first, out_second, out_third, alpha_out
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the alpha enable register
  logic              alpha_en_shadow;
  // converted pixels still to come out, oldest first
  pixel_out_t        pixels_due[$];

  int unsigned errors;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned reg_writes;
  int unsigned premul_words;
  int unsigned unpremul_words;
  int unsigned opaque_words;
  int unsigned zero_alpha_words;
  int unsigned idle_cycles;
  int unsigned cycle_count;

  premultiplied_alpha_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // corner pixels: full and zero alpha, identity at full alpha, truncation,
  // saturation, zero alpha on unpremultiply, and the opaque reorder path
  pixel_row_t corner_rows [NumRows] = '{
    '{1'b1, MODE_PREMUL,   8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 32'hffffffff},
    '{1'b1, MODE_PREMUL,   8'hff, 8'h80, 8'h00, 8'h00, 1'b1, 32'h00000000},
    '{1'b1, MODE_PREMUL,   8'h12, 8'h34, 8'h56, 8'hff, 1'b1, 32'hff123456},
    '{1'b1, MODE_PREMUL,   8'h01, 8'hfe, 8'h80, 8'h01, 1'b1, 32'h01000000},
    '{1'b1, MODE_UNPREMUL, 8'h0a, 8'h14, 8'h1e, 8'h00, 1'b1, 32'h00000000},
    '{1'b1, MODE_UNPREMUL, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 32'hffffffff},
    '{1'b1, MODE_UNPREMUL, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 32'h01000000},
    '{1'b1, MODE_UNPREMUL, 8'h01, 8'h00, 8'h01, 8'h01, 1'b1, 32'h01ff00ff},
    '{1'b1, MODE_UNPREMUL, 8'hc8, 8'hff, 8'h01, 8'h64, 1'b0, 32'h0},
    '{1'b1, MODE_PREMUL,   8'h64, 8'h96, 8'hc8, 8'h80, 1'b0, 32'h0},
    '{1'b1, MODE_UNPREMUL, 8'h40, 8'h20, 8'h10, 8'h80, 1'b0, 32'h0},
    '{1'b1, MODE_PREMUL,   8'haa, 8'h55, 8'hf0, 8'h0f, 1'b0, 32'h0},
    '{1'b1, MODE_UNPREMUL, 8'h55, 8'haa, 8'h0f, 8'hf0, 1'b0, 32'h0},
    '{1'b0, MODE_PREMUL,   8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 32'hff123456},
    '{1'b0, MODE_UNPREMUL, 8'hff, 8'h00, 8'h80, 8'h00, 1'b1, 32'hffff0080},
    '{1'b0, MODE_UNPREMUL, 8'h01, 8'h02, 8'h03, 8'h07, 1'b1, 32'hff010203},
    '{1'b0, MODE_PREMUL,   8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 32'hff000000},
    '{1'b1, MODE_UNPREMUL, 8'h7f, 8'h80, 8'hfe, 8'hfe, 1'b0, 32'h0}
  };

  // ---------------------------------------------------------------------------
  // conversion model
  // ---------------------------------------------------------------------------

  // floor(c * a / 255)
  function automatic logic [7:0] premul_chan(input logic [7:0] c, input logic [7:0] a);
    int unsigned prod;
    prod = int'(c) * int'(a);
    return 8'(prod / 255);
  endfunction

  // floor(c * 255 / a), saturated, zero for transparent pixels
  function automatic logic [7:0] unpremul_chan(input logic [7:0] c, input logic [7:0] a);
    int unsigned quot;
    if (a == 8'd0) begin
      return 8'd0;
    end
    quot = (int'(c) * 255) / int'(a);
    return (quot > 255) ? 8'hff : 8'(quot);
  endfunction

  // colour bytes leave in reverse order; opaque mode only reorders
  function automatic pixel_out_t convert_pixel(input logic en, input pam_mode_e mode,
                                               input logic [31:0] word);
    pixel_out_t px;
    logic [7:0] c0, c1, c2, a;
    c0 = word[7:0];
    c1 = word[15:8];
    c2 = word[23:16];
    a  = word[31:24];
    if (!en) begin
      px = '{alpha: 8'hff, third: c0, second: c1, first: c2};
    end else if (mode == MODE_PREMUL) begin
      px = '{alpha: a, third: premul_chan(c0, a), second: premul_chan(c1, a),
             first: premul_chan(c2, a)};
    end else begin
      px = '{alpha: a, third: unpremul_chan(c0, a), second: unpremul_chan(c1, a),
             first: unpremul_chan(c2, a)};
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // any handshake on either stream or the register port counts as progress
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, %0d pixels still due", $time, pixels_due.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  task automatic reg_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // the access completes at this edge
    rd = prdata;
    if (wr) begin
      reg_writes++;
      if (addr == AddrAlphaEnabled) begin
        alpha_en_shadow = data[0];
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle before the next access
    @(posedge clk_i);
  endtask

  task automatic check_enable_reg();
    logic [31:0] rd;
    reg_access(1'b0, AddrAlphaEnabled, 32'd0, rd);
    if (rd[0] !== alpha_en_shadow) begin
      errors++;
      $display("%0t: alpha enable readback expected %0b got %0b", $time,
               alpha_en_shadow, rd[0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one;
  // every fourth block of 128 words goes with no gaps at all
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((words_in / 128) % 4 == 3) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // drop valid and let the pipe run dry
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (PipeSlack) @(posedge clk_i);
  endtask

  task automatic set_alpha_enable(input logic en);
    logic [31:0] rd;
    logic [31:0] noise;
    drain_pipe();
    noise = $urandom;
    // upper bits are don't-care, toggle them anyway
    reg_access(1'b1, AddrAlphaEnabled, {noise[31:1], en}, rd);
    check_enable_reg();
  endtask

  // offer one word and queue its converted pixel at acceptance; valid stays
  // high into the next word when no gap is taken
  task automatic send_pixel(input pam_mode_e mode, input logic [31:0] word,
                            input logic known, input pixel_out_t given);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_due.push_back(known ? given : convert_pixel(alpha_en_shadow, mode, word));
    words_in++;
    if (!alpha_en_shadow) begin
      opaque_words++;
    end else if (mode == MODE_PREMUL) begin
      premul_words++;
    end else begin
      unpremul_words++;
    end
    if (word[31:24] == 8'd0) begin
      zero_alpha_words++;
    end
  endtask

  // alpha leans toward zero, full and tiny values
  function automatic logic [7:0] rand_alpha();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 8'h00;
    end else if (r < 16) begin
      return 8'hff;
    end else if (r < 24) begin
      return 8'($urandom_range(1, 3));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // premultiplied input is mostly well formed (colour not above alpha),
  // the rest drives the saturation path
  function automatic logic [7:0] rand_chan(input pam_mode_e mode, input logic [7:0] a);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 8'h00;
    end else if (r < 16) begin
      return 8'hff;
    end else if (mode == MODE_UNPREMUL && r < 80) begin
      return 8'($urandom_range(0, int'(a)));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  task automatic check_pixel(input pixel_out_t got);
    pixel_out_t want;
    if (pixels_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected output word %h", $time, got);
      return;
    end
    want = pixels_due.pop_front();
    if (got.first !== want.first) begin
      errors++;
      $display("%0t: out_first expected %h got %h", $time, want.first, got.first);
    end
    if (got.second !== want.second) begin
      errors++;
      $display("%0t: out_second expected %h got %h", $time, want.second, got.second);
    end
    if (got.third !== want.third) begin
      errors++;
      $display("%0t: out_third expected %h got %h", $time, want.third, got.third);
    end
    if (got.alpha !== want.alpha) begin
      errors++;
      $display("%0t: alpha_out expected %h got %h", $time, want.alpha, got.alpha);
    end
  endtask

  // output stalls: short ones often, long ones rarely, and in every fourth
  // stretch of the cycle counter no new stall starts, so ready is held high
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        check_pixel(pixel_out_t'(m_axis_tdata));
        words_out++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ((cycle_count / 256) % 4 != 1 && $urandom_range(0, 99) < 25) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 88) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    pixel_row_t  row;
    pam_mode_e   mode;
    logic [7:0]  a;
    logic [31:0] rd;
    logic        en_plan [NumPhases];
    errors           = 0;
    words_in         = 0;
    words_out        = 0;
    reg_writes       = 0;
    premul_words     = 0;
    unpremul_words   = 0;
    opaque_words     = 0;
    zero_alpha_words = 0;
    alpha_en_shadow  = 1'b1;
    en_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 32'd0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // enable must come out of reset set
    check_enable_reg();

    // corner table, switching the register whenever a row asks for it
    for (int i = 0; i < NumRows; i++) begin
      row = corner_rows[i];
      if (row.en !== alpha_en_shadow) begin
        set_alpha_enable(row.en);
      end
      send_pixel(row.mode, {row.a, row.c2, row.c1, row.c0}, row.known,
                 pixel_out_t'(row.res));
    end

    // random phases; each switch drains the pipe first
    for (int p = 0; p < NumPhases; p++) begin
      set_alpha_enable(en_plan[p]);
      if (p == 4) begin
        // a write to an address with no register must change nothing
        drain_pipe();
        reg_access(1'b1, AddrUnused, 32'd0, rd);
        check_enable_reg();
      end
      for (int n = 0; n < PhaseItems; n++) begin
        mode = pam_mode_e'($urandom_range(0, 1));
        a    = rand_alpha();
        send_pixel(mode, {a, rand_chan(mode, a), rand_chan(mode, a), rand_chan(mode, a)},
                   1'b0, '0);
        // now and then hold the input until every result is out
        if ($urandom_range(0, 299) == 0) begin
          drain_pipe();
        end
      end
    end

    drain_pipe();
    $display("covered %0d pixels: %0d premultiply, %0d unpremultiply, %0d opaque,",
             words_in, premul_words, unpremul_words, opaque_words);
    $display("  %0d with zero alpha, %0d results checked, %0d register writes, %0d errors",
             zero_alpha_words, words_out, reg_writes, errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
